// ----- src/randomized_set_swap_remove_assert.svh -----
// ----------------------------------------------------------------------------
// randomized set assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef RANDOMIZED_SET_SWAP_REMOVE_ASSERT_SVH
`define RANDOMIZED_SET_SWAP_REMOVE_ASSERT_SVH

// same-cycle implication, off during reset
`define RSS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("rss port check failed");

// next-cycle implication, off during reset
`define RSS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("rss port check failed");

`endif

// ----- src/rss_pkg.sv -----
// ----------------------------------------------------------------------------
// rss_pkg
// types and sizes shared by the randomized set and its checker
// ----------------------------------------------------------------------------
package rss_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int RND_W    = 31;
	localparam int BIT_W    = $clog2(RND_W);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_RANDOM = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_PRESENCE = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		func_t                    func;
		logic signed [VAL_W-1:0]  item_value;
		logic        [RND_W-1:0]  random_word;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic signed [VAL_W-1:0]  picked_value;
	} res_t;

endpackage

// ----- src/randomized_set_swap_remove.sv -----
// ----------------------------------------------------------------------------
// randomized_set_swap_remove
// dense set of distinct 32-bit values with insert, swap-remove and
// random pick, run by a small sequencer around one entry memory
// ----------------------------------------------------------------------------
// channel   dir   handshake            payload
// request   in    start, busy          req  (func, item_value, random_word)
// result    out   done (1-cycle pulse) res  (status, picked_value)
//
// an item is taken when start is high and busy is low; busy stays high
// until its result is out. one result per item, on done for one cycle.
// insert/remove: each live entry searched takes a read step and a compare
// step (one memory read port), then the write, move or answer.
// random pick: one-bit restoring modulo of the random word by the count,
// one remainder bit per step, then read the chosen entry and answer.
// empty pick and unused codes are answered directly from idle.
// reset clears sequencer, count and result, not the entries; entries past the count are never used.
// the receiver cannot stall, so there is no back-pressure on done.
// ----------------------------------------------------------------------------
module randomized_set_swap_remove (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rss_pkg::req_t req,
	output logic          done,
	output rss_pkg::res_t res
);
	import rss_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,    // scan: drive search address
		S_CMP,   // scan: compare read data
		S_LAST,  // read last live entry for the swap
		S_MOVE,  // write last entry into the freed slot
		S_MOD,   // one remainder bit per cycle
		S_PICK,  // read entry at the remainder
		S_PVAL   // hand out picked entry
	} state_t;

	state_t state_q;

	// request and working registers
	req_t             req_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic [CNT_W-1:0] slot_q;
	logic [CNT_W-1:0] rem_q;
	logic [RND_W-1:0] rnd_q;
	logic [BIT_W-1:0] bit_q;
	logic             done_q;
	res_t             res_q;

	// entry memory, one write and one registered read port
	logic [VAL_W-1:0] mem_q [CAPACITY];
	logic [VAL_W-1:0] rd_data_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;

	logic             accept;
	logic             scan_end;
	logic             hit;
	logic [CNT_W-1:0] last_idx;
	logic [CNT_W:0]   rem_shift;
	logic             rem_ge;
	logic [CNT_W:0]   rem_sub;

	assign accept    = start && (state_q == S_IDLE);
	assign scan_end  = (scan_q == count_q);
	assign hit       = (rd_data_q == req_q.item_value);
	assign last_idx  = count_q - CNT_W'(1);

	// restoring-modulo step: shift in next word bit, subtract count if it fits
	assign rem_shift = {rem_q, rnd_q[RND_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, count_q});
	assign rem_sub   = rem_shift - {1'b0, count_q};

	// memory read address follows the sequencer step
	always_comb begin
		unique case (state_q)
			S_LAST:  rd_addr = last_idx[IDX_W-1:0];
			S_PICK:  rd_addr = rem_q[IDX_W-1:0];
			default: rd_addr = scan_q[IDX_W-1:0];
		endcase
	end

	// writes: append on insert, fill the freed slot on remove
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = req_q.item_value;
		if (state_q == S_RD && scan_end && req_q.func == OP_INSERT &&
			count_q != CNT_W'(CAPACITY)) begin
			wr_en = 1'b1;
		end else if (state_q == S_MOVE) begin
			wr_en   = 1'b1;
			wr_addr = slot_q[IDX_W-1:0];
			wr_data = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req;
			scan_q <= '0;
			rem_q  <= '0;
			rnd_q  <= req.random_word;
			bit_q  <= BIT_W'(RND_W - 1);
		end else begin
			unique case (state_q)
				S_CMP: begin
					slot_q <= scan_q;
					scan_q <= scan_q + CNT_W'(1);
				end
				S_MOD: begin
					rem_q <= rem_ge ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
					rnd_q <= rnd_q << 1;
					bit_q <= bit_q - BIT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer, count and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q             <= 1'b0;
			res_q.picked_value <= '0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (req.func)
							OP_INSERT, OP_REMOVE: state_q <= S_RD;
							OP_RANDOM: begin
								if (count_q == '0) begin
									done_q       <= 1'b1;
									res_q.status <= ST_EMPTY;
								end else begin
									state_q <= S_MOD;
								end
							end
							default: begin
								// unused code: answer done, no change
								done_q       <= 1'b1;
								res_q.status <= ST_DONE;
							end
						endcase
					end
				end
				S_RD: begin
					if (scan_end) begin
						// value absent
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						if (req_q.func == OP_INSERT) begin
							if (count_q == CNT_W'(CAPACITY)) begin
								res_q.status <= ST_FULL;
							end else begin
								res_q.status <= ST_DONE;
								count_q      <= count_q + CNT_W'(1);
							end
						end else begin
							res_q.status <= ST_PRESENCE;
						end
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (hit) begin
						if (req_q.func == OP_INSERT) begin
							state_q      <= S_IDLE;
							done_q       <= 1'b1;
							res_q.status <= ST_PRESENCE;
						end else begin
							state_q <= S_LAST;
						end
					end else begin
						state_q <= S_RD;
					end
				end
				S_LAST: state_q <= S_MOVE;
				S_MOVE: begin
					state_q      <= S_IDLE;
					count_q      <= last_idx;
					done_q       <= 1'b1;
					res_q.status <= ST_DONE;
				end
				S_MOD: begin
					if (bit_q == '0) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: state_q <= S_PVAL;
				S_PVAL: begin
					state_q            <= S_IDLE;
					done_q             <= 1'b1;
					res_q.status       <= ST_DONE;
					res_q.picked_value <= rd_data_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- src/rss_checker.sv -----
// ----------------------------------------------------------------------------
// rss_checker
// port-level checks for the randomized set, attached by bind
// ----------------------------------------------------------------------------
`include "randomized_set_swap_remove_assert.svh"

module rss_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input rss_pkg::res_t res
);
	import rss_pkg::*;

	// a result always closes the item, never overlaps work
	`RSS_ASSERT_IMPL(a_done_not_busy, clk, arst_n, done, !busy)

	// a taken item either starts work or answers at once
	`RSS_ASSERT_NEXT(a_accept_moves, clk, arst_n, start && !busy, busy || done)

	// busy only rises from a taken item
	`RSS_ASSERT_IMPL(a_busy_from_start, clk, arst_n, $rose(busy), $past(start))

	// a result whose status is not done carries a zero value
	`RSS_ASSERT_IMPL(a_pick_zero, clk, arst_n,
		done && res.status != ST_DONE, res.picked_value == '0)

endmodule

bind randomized_set_swap_remove rss_checker u_rss_checker (.*);
